// File: rtl/utf8_decoder_with_replacement_defines.svh
// Assertion macros for the UTF-8 decoder RTL.
// Used by utf8d_back, which carries concurrent assertions; the macros expect clk and rst_n in scope.
`ifndef UTF8_DECODER_WITH_REPLACEMENT_DEFINES_SVH
`define UTF8_DECODER_WITH_REPLACEMENT_DEFINES_SVH
`ifndef SYNTHESIS
`define UTF8D_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UTF8D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define UTF8D_ASSERT(lbl, prop, msg)
`define UTF8D_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/utf8d_pkg.sv
// Package for the UTF-8 decoder: payload and command types, byte constants, helpers.
// No dependencies; imported by every module of the decoder.
package utf8d_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned REP_W = 3;

    localparam logic [CP_W-1:0] REPL_CP = 21'd63;

    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD_ED   = 8'hED;
    localparam logic [7:0] CONT_A0   = 8'hA0;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam logic [7:0] CONT_90   = 8'h90;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } utf8d_in_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            end_of_text;
    } utf8d_out_t;

    // One queue entry: rep_cnt replacements, then the code point if has_cp.
    typedef struct packed {
        logic [REP_W-1:0] rep_cnt;
        logic             has_cp;
        logic [CP_W-1:0]  cp;
        logic             eot;
    } utf8d_cmd_t;

    // Sequence length of a lead byte, 1 to 4, or 0 when the byte cannot lead.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b < CONT_TAG)
            len = 3'd1;
        else if (b >= LEAD2_LO && b <= LEAD2_HI)
            len = 3'd2;
        else if (b >= LEAD3_LO && b <= LEAD3_HI)
            len = 3'd3;
        else if (b >= LEAD4_LO && b <= LEAD4_HI)
            len = 3'd4;
        return len;
    endfunction

    // Whether b may follow lead; the range limits apply only to the second byte.
    function automatic logic follow_ok(input logic [7:0] lead, input logic second,
                                       input logic [7:0] b);
        logic ok;
        ok = ((b & CONT_MASK) == CONT_TAG);
        if (second)
        begin
            if (lead == LEAD3_LO && b < CONT_A0)
                ok = 1'b0;
            if (lead == LEAD_ED && b >= CONT_A0)
                ok = 1'b0;
            if (lead == LEAD4_LO && b < CONT_90)
                ok = 1'b0;
            if (lead == LEAD4_HI && b >= CONT_90)
                ok = 1'b0;
        end
        return ok;
    endfunction

    // Code point of a complete sequence; acc holds the earlier continuation payloads.
    function automatic logic [CP_W-1:0] build_cp(input logic [7:0] lead,
                                                 input logic [11:0] acc,
                                                 input logic [7:0] b,
                                                 input logic [2:0] len);
        logic [CP_W-1:0] cp;
        case (len)
            3'd2:    cp = {10'd0, lead[4:0], b[5:0]};
            3'd3:    cp = {5'd0, lead[3:0], acc[5:0], b[5:0]};
            default: cp = {lead[2:0], acc[11:0], b[5:0]};
        endcase
        return cp;
    endfunction

endpackage

// File: rtl/utf8_decoder_with_replacement.sv
// Streaming UTF-8 decoder with '?' replacement for invalid or truncated sequences.
// Throughput: one byte per cycle while the command queue is not full.
// A result passes through the command queue, then the command and output registers of the back end.
// Rate is set by the back end, which sends one result per cycle from the command queue unless stalled.
// Reset (rst_n low, asynchronous) empties the queue, drops the open sequence and the output.
module utf8_decoder_with_replacement
    import utf8d_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 5
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  utf8d_in_t  byte_item,
    output logic       cp_valid,
    input  logic       cp_stall,
    output utf8d_out_t cp_item
);

    // The front end holds the lead byte and continuation payload bits of an
    // unfinished sequence. For each byte transfer it decides everything that
    // byte settles at once: how many '?' results a broken or truncated sequence
    // produces, and whether a decoded code point follows them. That decision
    // travels as a single command, so the front end never waits for output.
    //
    // Total results never exceed total bytes, so a back end that sends one
    // result per cycle keeps pace on average. The queue absorbs the bursts
    // where a broken sequence releases several replacements at once; the
    // front end stalls only while the queue is full. A command with four
    // results lets three more commands pile up behind the one already
    // waiting, so five entries keep a full-rate byte stream moving as long
    // as the result side does not stall.

    logic       q_full;
    logic       q_push;
    utf8d_cmd_t q_cmd;
    logic       q_pop;
    logic       q_not_empty;
    utf8d_cmd_t q_head;

    utf8d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_cmd  (q_head)
    );

    // The back end keeps the command in service plus a registered output
    // stage; while a result stalls, a command is loaded only if none is in service.
    utf8d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .cp_valid    (cp_valid),
        .cp_stall    (cp_stall),
        .cp_item     (cp_item)
    );

endmodule

// File: rtl/utf8d_front.sv
// Front end of the UTF-8 decoder: takes bytes, tracks the open sequence, classifies.
// Depends on utf8d_pkg; pushes one command per byte that yields results.
module utf8d_front
    import utf8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  utf8d_in_t  byte_item,
    input  logic       q_full,
    output logic       q_push,
    output utf8d_cmd_t q_cmd
);

    logic [1:0]  pend_cnt_reg, pend_cnt_next;
    logic [7:0]  lead_reg, lead_next;
    logic [11:0] acc_reg, acc_next;

    logic        accept;
    logic [7:0]  b;
    logic        fin;
    logic [2:0]  plen;
    logic [2:0]  blen;
    logic [2:0]  rep0;
    logic        fits;
    logic        has_res;

    assign byte_stall = q_full;
    assign accept     = byte_valid && !q_full;
    assign b          = byte_item.data_byte;
    assign fin        = byte_item.final_byte;
    assign plen       = lead_len(lead_reg);
    assign blen       = lead_len(b);
    assign rep0       = {1'b0, pend_cnt_reg};
    assign fits       = (pend_cnt_reg != 2'd0)
                        && follow_ok(lead_reg, pend_cnt_reg == 2'd1, b);

    always_comb
    begin
        pend_cnt_next = pend_cnt_reg;
        lead_next     = lead_reg;
        acc_next      = acc_reg;
        has_res       = 1'b0;
        q_cmd         = '{rep_cnt: '0, has_cp: 1'b0, cp: '0, eot: fin};
        if (fits)
        begin
            if (rep0 + 3'd1 == plen)
            begin
                has_res       = 1'b1;
                q_cmd.has_cp  = 1'b1;
                q_cmd.cp      = build_cp(lead_reg, acc_reg, b, plen);
                pend_cnt_next = 2'd0;
            end
            else if (fin)
            begin
                // Cut short: the lead, every buffered continuation and this final byte become '?'.
                has_res       = 1'b1;
                q_cmd.rep_cnt = rep0 + 3'd1;
                pend_cnt_next = 2'd0;
            end
            else
            begin
                pend_cnt_next = pend_cnt_reg + 2'd1;
                acc_next      = {acc_reg[5:0], b[5:0]};
            end
        end
        else
        begin
            // Any open sequence is broken; the new byte starts afresh.
            q_cmd.rep_cnt = rep0;
            pend_cnt_next = 2'd0;
            if (blen == 3'd1)
            begin
                has_res      = 1'b1;
                q_cmd.has_cp = 1'b1;
                q_cmd.cp     = {13'd0, b};
            end
            else if (blen == 3'd0 || fin)
            begin
                has_res       = 1'b1;
                q_cmd.rep_cnt = rep0 + 3'd1;
            end
            else
            begin
                has_res       = (rep0 != 3'd0);
                pend_cnt_next = 2'd1;
                lead_next     = b;
            end
        end
    end

    assign q_push = accept && has_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_cnt_reg <= 2'd0;
        else if (accept)
            pend_cnt_reg <= pend_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lead_reg <= lead_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

// File: rtl/utf8d_queue.sv
// Command queue between the front and back ends of the UTF-8 decoder.
// Depends on utf8d_pkg for the command type; DEPTH entries, first in first out.
module utf8d_queue
    import utf8d_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  utf8d_cmd_t push_cmd,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output utf8d_cmd_t head_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    utf8d_cmd_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: rtl/utf8d_back.sv
// Back end of the UTF-8 decoder: expands queued commands into results, one per cycle when not stalled.
// Depends on utf8d_pkg and the assertion macro header; drives the output register.
`include "utf8_decoder_with_replacement_defines.svh"
module utf8d_back
    import utf8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_not_empty,
    input  utf8d_cmd_t q_head,
    output logic       q_pop,
    output logic       cp_valid,
    input  logic       cp_stall,
    output utf8d_out_t cp_item
);

    logic       cur_valid_reg, cur_valid_next;
    utf8d_cmd_t cur_reg, cur_next;
    logic       out_valid_reg, out_valid_next;
    utf8d_out_t out_reg, out_next;

    logic slot_free;
    logic emit;
    logic last;
    logic done;
    logic take;

    assign slot_free = !out_valid_reg || !cp_stall;
    assign emit      = cur_valid_reg && slot_free;
    assign last      = (cur_reg.rep_cnt == '0)
                       || (cur_reg.rep_cnt == REP_W'(1) && !cur_reg.has_cp);
    assign done      = emit && last;
    assign take      = q_not_empty && (!cur_valid_reg || done);
    assign q_pop     = take;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit && !last)
            cur_next.rep_cnt = cur_reg.rep_cnt - 1'b1;
        if (take)
        begin
            cur_valid_next = 1'b1;
            cur_next       = q_head;
        end
        else if (done)
            cur_valid_next = 1'b0;
        if (slot_free)
            out_valid_next = cur_valid_reg;
        if (emit)
        begin
            if (cur_reg.rep_cnt != '0)
                out_next = '{code_point: REPL_CP, replaced: 1'b1,
                             end_of_text: cur_reg.eot && last};
            else
                out_next = '{code_point: cur_reg.cp, replaced: 1'b0,
                             end_of_text: cur_reg.eot};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign cp_valid = out_valid_reg;
    assign cp_item  = out_reg;

    `UTF8D_ASSERT(a_cmd_not_empty, cur_valid_reg |-> (cur_reg.rep_cnt != '0 || cur_reg.has_cp), "queued command carries no result")
    `UTF8D_ASSERT(a_repl_value, (out_valid_reg && out_reg.replaced) |-> (out_reg.code_point == REPL_CP), "replacement result has wrong code point")
    `UTF8D_ASSERT_NEXT(a_cmd_held, emit && !last, cur_valid_reg && out_valid_reg, "command dropped before all results were sent")

endmodule

// File: tb/tb.sv
// Self-checking testbench for the streaming UTF-8 decoder with '?' replacement.
// Depends on utf8d_pkg for the byte and code point payload types and on the decoder RTL.
// A built-in byte-level decoder predicts every result; directed texts come first, then mostly random ones.
module tb;

    import utf8d_pkg::*;

    // The watchdog ends the run once this limit is reached with no transfer on either side.
    localparam int unsigned IDLE_LIMIT   = 2000;
    // Cycles to wait after the last expected code point, to catch any extra result.
    localparam int unsigned DRAIN_CYCLES = 8;

    logic       clk;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_stall;
    utf8d_in_t  byte_item;
    logic       cp_valid;
    logic       cp_stall;
    utf8d_out_t cp_item;

    // Predicted code points, oldest first, in the order the decoder must deliver them.
    utf8d_out_t  expected_results [$];
    // Bytes of an incomplete but so far valid sequence, lead byte first.
    logic [7:0]  held_bytes [3];
    int unsigned held_count = 0;

    // Bytes of the random text that is being built before it is sent.
    logic [7:0]  text_bytes [$];

    int unsigned err_count  = 0;
    int unsigned bytes_sent = 0;
    // When set, neither side inserts idle or stall cycles.
    bit          no_idle    = 1'b0;

    utf8_decoder_with_replacement i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .cp_valid   (cp_valid),
        .cp_stall   (cp_stall),
        .cp_item    (cp_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Length of the sequence that a byte opens, or 0 when it cannot open one.
    function automatic int unsigned seq_length(input logic [7:0] b);
        if (b[7] == 1'b0)
            return 1;
        if (b >= 8'hC2 && b <= 8'hDF)
            return 2;
        if (b[7:4] == 4'hE)
            return 3;
        if (b >= 8'hF0 && b <= 8'hF4)
            return 4;
        return 0;
    endfunction

    // A continuation must be 10xxxxxx. The second byte after E0, ED, F0 and F4 is
    // further limited so that overlong forms, surrogates and values past 10FFFF fail.
    function automatic bit fits_after(input logic [7:0] lead, input bit second,
                                      input logic [7:0] b);
        if (b[7:6] != 2'b10)
            return 1'b0;
        if (!second)
            return 1'b1;
        case (lead)
            8'hE0:   return b >= 8'hA0;
            8'hED:   return b < 8'hA0;
            8'hF0:   return b >= 8'h90;
            8'hF4:   return b < 8'h90;
            default: return 1'b1;
        endcase
    endfunction

    // Decodes one accepted byte against the held bytes and queues the code points
    // that it releases. An invalid or cut-short sequence costs only its lead byte;
    // decoding restarts at the byte after it.
    function automatic void predict_decode(input logic [7:0] b, input logic fin);
        logic [7:0]      window [4];
        utf8d_out_t      fresh [$];
        utf8d_out_t      r;
        int unsigned     n;
        int unsigned     head;
        int unsigned     len;
        int unsigned     avail;
        int unsigned     lim;
        int unsigned     k;
        bit              bad;
        bit              waiting;
        logic [CP_W-1:0] cp;
        n       = 0;
        head    = 0;
        waiting = 1'b0;
        for (k = 0; k < held_count; k++)
        begin
            window[n] = held_bytes[k];
            n++;
        end
        window[n] = b;
        n++;
        while (head < n && !waiting)
        begin
            len   = seq_length(window[head]);
            avail = n - head;
            r.end_of_text = 1'b0;
            r.replaced    = 1'b1;
            r.code_point  = REPL_CP;
            if (len == 1)
            begin
                r.code_point = {13'd0, window[head]};
                r.replaced   = 1'b0;
                fresh = {fresh, r};
                head++;
            end
            else if (len == 0)
            begin
                fresh = {fresh, r};
                head++;
            end
            else
            begin
                lim = (avail < len) ? avail : len;
                bad = 1'b0;
                for (k = 1; k < lim; k++)
                    if (!fits_after(window[head], k == 1, window[head + k]))
                        bad = 1'b1;
                if (bad)
                begin
                    fresh = {fresh, r};
                    head++;
                end
                else if (avail >= len)
                begin
                    case (len)
                        2: cp = {10'd0, window[head][4:0], window[head + 1][5:0]};
                        3: cp = {5'd0, window[head][3:0], window[head + 1][5:0],
                                 window[head + 2][5:0]};
                        default: cp = {window[head][2:0], window[head + 1][5:0],
                                       window[head + 2][5:0], window[head + 3][5:0]};
                    endcase
                    r.code_point = cp;
                    r.replaced   = 1'b0;
                    fresh = {fresh, r};
                    head += len;
                end
                else if (fin)
                begin
                    // The text ends inside the sequence: the lead becomes '?'.
                    fresh = {fresh, r};
                    head++;
                end
                else
                    waiting = 1'b1;
            end
        end
        if (fin)
        begin
            held_count = 0;
            if (fresh.size() != 0)
                fresh[fresh.size() - 1].end_of_text = 1'b1;
        end
        else
        begin
            held_count = n - head;
            for (k = 0; k < held_count; k++)
                held_bytes[k] = window[head + k];
        end
        foreach (fresh[i])
            expected_results = {expected_results, fresh[i]};
    endfunction

    // ------------------------------------------------------------------
    // Error reporting and result checking
    // ------------------------------------------------------------------

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic void check_code_point(input utf8d_out_t got);
        utf8d_out_t want;
        if (expected_results.size() == 0)
        begin
            note_error($sformatf("unexpected result: cp=%06h replaced=%0b end=%0b",
                                 got.code_point, got.replaced, got.end_of_text));
            return;
        end
        want = expected_results.pop_front();
        if (got.code_point !== want.code_point || got.replaced !== want.replaced ||
            got.end_of_text !== want.end_of_text)
            note_error($sformatf({"mismatch: expected cp=%06h replaced=%0b end=%0b, ",
                                  "got cp=%06h replaced=%0b end=%0b"},
                                 want.code_point, want.replaced, want.end_of_text,
                                 got.code_point, got.replaced, got.end_of_text));
    endfunction

    // Wait drawn for each item by either side; zero while a no-idle stretch runs.
    function automatic int unsigned pick_wait();
        if (no_idle)
            return 0;
        return $urandom_range(0, 4);
    endfunction

    // The receiving side. After each accepted code point it draws a number of cycles
    // during which it holds stall high. All sampling happens right after the rising
    // edge, so the values seen are the ones the decoder presented during that edge.
    initial
    begin : result_monitor
        int unsigned hold;
        hold = 0;
        cp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && cp_valid && !cp_stall)
            begin
                check_code_point(cp_item);
                hold = pick_wait();
            end
            else if (hold != 0)
                hold--;
            cp_stall <= (hold != 0);
        end
    end

    // Watchdog: any transfer on either side restarts the count.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((byte_valid && !byte_stall) || (cp_valid && !cp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Byte sender
    // ------------------------------------------------------------------

    // Sends one byte. Valid stays high after the transfer, so back-to-back bytes need
    // no extra assignment; a gap lowers it at the edge of the previous transfer.
    // The prediction is made at the edge where the transfer happens.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int unsigned gap;
        utf8d_in_t   item;
        gap             = pick_wait();
        item.data_byte  = b;
        item.final_byte = fin;
        if (gap != 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= item;
        do
            @(posedge clk);
        while (byte_stall);
        predict_decode(b, fin);
        bytes_sent++;
    endtask

    // Stops sending until every predicted code point has arrived. At least one edge
    // passes, so valid is never lowered and raised again within one time step.
    task automatic wait_drained();
        byte_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Random text generation
    // ------------------------------------------------------------------

    // Adds one byte at the end of the text under construction.
    function automatic void add_text_byte(input logic [7:0] b);
        text_bytes = {text_bytes, b};
    endfunction

    // Appends the UTF-8 form of a scalar value to the text under construction.
    function automatic void append_utf8(input logic [CP_W-1:0] cp);
        if (cp < 21'h80)
            add_text_byte(cp[7:0]);
        else if (cp < 21'h800)
        begin
            add_text_byte({3'b110, cp[10:6]});
            add_text_byte({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            add_text_byte({4'b1110, cp[15:12]});
            add_text_byte({2'b10, cp[11:6]});
            add_text_byte({2'b10, cp[5:0]});
        end
        else
        begin
            add_text_byte({5'b11110, cp[20:18]});
            add_text_byte({2'b10, cp[17:12]});
            add_text_byte({2'b10, cp[11:6]});
            add_text_byte({2'b10, cp[5:0]});
        end
    endfunction

    // Draws a scalar value of the given encoded length (1 to 4), never a surrogate.
    function automatic logic [CP_W-1:0] random_scalar(input int unsigned len);
        logic [CP_W-1:0] cp;
        case (len)
            1: cp = CP_W'($urandom_range(0, 'h7F));
            2: cp = CP_W'($urandom_range('h80, 'h7FF));
            3:
            begin
                cp = CP_W'($urandom_range('h800, 'hF7FF));
                if (cp >= 21'hD800)
                    cp = cp + 21'h800;
            end
            default: cp = CP_W'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    // Appends bytes that are often invalid: a raw random byte, a sequence
    // missing its last byte, a sequence with one corrupted continuation, or a bad
    // or range-limited lead byte followed by two arbitrary continuations.
    function automatic void append_noise();
        int unsigned start;
        int unsigned len;
        start = text_bytes.size();
        len   = $urandom_range(2, 4);
        case ($urandom_range(0, 3))
            0: add_text_byte(8'($urandom_range(0, 255)));
            1:
            begin
                append_utf8(random_scalar(len));
                void'(text_bytes.pop_back());
            end
            2:
            begin
                append_utf8(random_scalar(len));
                text_bytes[start + $urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
            end
            default:
            begin
                case ($urandom_range(0, 8))
                    0: add_text_byte(8'hC0);
                    1: add_text_byte(8'hC1);
                    2: add_text_byte(8'hF5);
                    3: add_text_byte(8'hFF);
                    4: add_text_byte(8'hE0);
                    5: add_text_byte(8'hED);
                    6: add_text_byte(8'hF0);
                    7: add_text_byte(8'hF4);
                    default: add_text_byte(8'hF8);
                endcase
                add_text_byte(8'($urandom_range(8'h80, 8'hBF)));
                add_text_byte(8'($urandom_range(8'h80, 8'hBF)));
            end
        endcase
    endfunction

    // Builds a text of mostly well-formed sequences with some noise mixed in and
    // sends it, marking its last byte as final.
    task automatic send_random_text(input int unsigned max_seqs);
        int unsigned count;
        count = $urandom_range(1, max_seqs);
        text_bytes.delete();
        repeat (count)
        begin
            if ($urandom_range(0, 7) == 0)
                append_noise();
            else
                append_utf8(random_scalar($urandom_range(1, 4)));
        end
        for (int i = 0; i < text_bytes.size(); i++)
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Smallest and largest single-byte characters; the second one ends the text.
    task automatic test_ascii_bounds();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    // The lowest two- and three-byte forms and the highest four-byte form.
    task automatic test_valid_multibyte();
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // Bytes that can never lead, and a stray continuation byte.
    task automatic test_bad_leads();
        send_byte(8'hC0, 1'b0);
        send_byte(8'hF5, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // Second bytes just outside the range their lead allows (overlong three- and
    // four-byte forms, a surrogate, a value past 10FFFF), then a lead followed by
    // a plain character instead of a continuation.
    task automatic test_bad_continuation();
        send_byte(8'hE0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'h41, 1'b1);
    endtask

    // The text ends inside a three-byte sequence: the lead and then the final
    // continuation byte each give a replacement.
    task automatic test_cut_short();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
    endtask

    // Random texts with random gaps and stalls; now and then the sender waits until
    // the decoder has delivered everything.
    task automatic test_random_text(input int unsigned target);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            send_random_text(16);
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
    endtask

    // A text left open without a final byte, so bytes stay held while the sender
    // pauses; once all results are in, the text is completed.
    task automatic test_pause_until_drained();
        send_byte(8'h41, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        wait_drained();
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        send_random_text(8);
        wait_drained();
    endtask

    // Full rate on both sides, to keep the result queue under pressure.
    task automatic test_back_to_back(input int unsigned target);
        int unsigned start;
        start   = bytes_sent;
        no_idle = 1'b1;
        while (bytes_sent - start < target)
            send_random_text(24);
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_item  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ascii_bounds();
        test_valid_multibyte();
        test_bad_leads();
        test_bad_continuation();
        test_cut_short();
        test_random_text(300);
        test_pause_until_drained();
        test_back_to_back(150);
        test_random_text(60);

        // Everything is sent: wait for the last results, then a little longer so
        // that a spurious extra result is still seen by the checker.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            note_error($sformatf("%0d expected results never arrived",
                                 expected_results.size()));
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/utf8d_pkg.sv
rtl/utf8d_front.sv
rtl/utf8d_queue.sv
rtl/utf8d_back.sv
rtl/utf8_decoder_with_replacement.sv
tb/tb.sv
